[hdl/ulz_pkg.sv]
// ----------------------------------------------------------------------------
// ulz_pkg
// Shared types, constants and codes for the ULZ back-reference decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ulz_pkg;

    // History window, must be a power of two (2048 .. 32768)
    localparam int WINDOW_DEPTH = 32768;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);

    localparam int SIZE_W    = 24;
    localparam int DBITS_W   = 4;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 6;   // up to 34 bytes per match
    localparam int MIN_MATCH = 3;

    localparam logic [DBITS_W-1:0] DBITS_MIN   = 4'd11;
    localparam logic [DBITS_W-1:0] DBITS_MAX   = 4'd15;
    localparam logic [DBITS_W-1:0] DBITS_RESET = 4'd12;

    // Register indexes
    localparam logic REG_DISTANCE_BITS = 1'b0;
    localparam logic REG_TOTAL_SIZE    = 1'b1;

    // Result error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_FAR     = 2'd2;

    typedef struct packed {
        logic              is_match;
        logic [7:0]        literal;
        logic [CODE_W-1:0] match_code;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
        logic [1:0] error_code;
    } out_t;

    typedef struct packed {
        logic [DBITS_W-1:0] distance_bits;
        logic [SIZE_W-1:0]  total_size;
    } cfg_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [SIZE_W-1:0] a;
        logic [SIZE_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [SIZE_W-1:0] sum;
        logic              borrow;  // a < b on subtract
    } alu_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK_DONE,
        ST_CHECK_LEN,
        ST_CHECK_DIST,
        ST_READ,
        ST_EMIT,
        ST_ERROR
    } state_t;

endpackage

`default_nettype wire

[hdl/ulz_lz77_decompressor_top.sv]
// ----------------------------------------------------------------------------
// ulz_lz77_decompressor_top
// ULZ type 2 back-reference decoder: literal and match tokens in, bytes out.
// ----------------------------------------------------------------------------
// One token is taken at a time; in_ready is high only while the sequencer is
// idle. A literal passes through accept, end-of-stream check and emit. A match
// gives L = 3..34 output bytes: three checks run one after another through
// the single shared 24-bit add/subtract unit (bytes left, length against bytes
// left, distance against bytes written), then each byte is read from the
// history RAM and written back as it loads the output register. A rejected
// token gives one error beat. The output register lets the next token be
// taken while the last beat still waits for out_ready; the sequencer stalls
// in the emit or error step only when that register is still full. The
// history window holds no reset state: the distance check never lets a read
// reach an unwritten entry, so no clearing pass runs after reset. The user
// must write configuration only while the block is idle; the block does not
// enforce it. Writing total_size leaves the byte count as it is.
// ----------------------------------------------------------------------------
`default_nettype none

module ulz_lz77_decompressor_top (
    input  wire                        clk,
    input  wire                        rst_n,
    // configuration
    input  wire                        cfg_we,
    input  wire                        cfg_index,
    input  wire [ulz_pkg::SIZE_W-1:0]  cfg_wdata,
    // token beats
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire ulz_pkg::in_t          in_data,
    // result beats
    output logic                       out_valid,
    input  wire                        out_ready,
    output ulz_pkg::out_t              out_beat
);
    import ulz_pkg::*;

    logic [DBITS_W-1:0] distance_bits_reg;
    logic [SIZE_W-1:0]  total_size_reg;
    cfg_t               cfg;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    // Configuration registers; only the low bits of the data bus matter
    // for distance_bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_bits_reg <= DBITS_RESET;
            total_size_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DISTANCE_BITS: distance_bits_reg <= cfg_wdata[DBITS_W-1:0];
                REG_TOTAL_SIZE:    total_size_reg    <= cfg_wdata;
                default:           total_size_reg    <= total_size_reg;
            endcase
        end
    end

    assign cfg = '{distance_bits: distance_bits_reg, total_size: total_size_reg};

    // Sequencer: checks, copy loop, byte counter, output register
    ulz_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Shared add/subtract unit, one operation per sequencer step
    ulz_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // History window, byte p of the stream at entry p mod window depth
    ulz_history_ram u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[hdl/ulz_alu.sv]
// ----------------------------------------------------------------------------
// ulz_alu
// Shared 24-bit add / subtract unit used by the check and emit steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ulz_alu (
    input  wire ulz_pkg::alu_req_t req,
    output ulz_pkg::alu_rsp_t      rsp
);
    import ulz_pkg::*;

    logic [SIZE_W:0] wide;

    always_comb
    begin
        case (req.op)
            ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            default: wide = '0;
        endcase
        rsp.sum    = wide[SIZE_W-1:0];
        rsp.borrow = wide[SIZE_W];
    end

endmodule

`default_nettype wire

[hdl/ulz_history_ram.sv]
// ----------------------------------------------------------------------------
// ulz_history_ram
// History window: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ulz_history_ram (
    input  wire                       clk,
    input  wire                       we,
    input  wire [ulz_pkg::ADDR_W-1:0] waddr,
    input  wire [7:0]                 wdata,
    input  wire                       re,
    input  wire [ulz_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                rdata
);
    import ulz_pkg::*;

    logic [7:0] mem [WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/ulz_seq.sv]
// ----------------------------------------------------------------------------
// ulz_seq
// Token sequencer: checks, copy loop, byte counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ulz_seq (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire ulz_pkg::cfg_t         cfg,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire ulz_pkg::in_t          in_data,
    output logic                       out_valid,
    input  wire                        out_ready,
    output ulz_pkg::out_t              out_beat,
    output ulz_pkg::alu_req_t          alu_req,
    input  wire ulz_pkg::alu_rsp_t     alu_rsp,
    output logic                       ram_we,
    output logic [ulz_pkg::ADDR_W-1:0] ram_waddr,
    output logic [7:0]                 ram_wdata,
    output logic                       ram_re,
    output logic [ulz_pkg::ADDR_W-1:0] ram_raddr,
    input  wire [7:0]                  ram_rdata
);
    import ulz_pkg::*;

    state_t             state_reg, state_next;
    in_t                tok_reg;
    logic [SIZE_W-1:0]  produced_reg;
    logic [SIZE_W-1:0]  remaining_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [ADDR_W-1:0]  src_reg;
    logic [1:0]         err_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    logic [DBITS_W-1:0] bits_eff;
    logic [CODE_W-1:0]  dist_mask;
    logic [CODE_W-1:0]  dist_m1;
    logic [CODE_W-1:0]  distance;
    logic [CODE_W-1:0]  len_shift;
    logic [LEN_W-1:0]   match_len;
    logic               too_far;
    logic               slot_free;
    logic               emit_fire;
    logic               err_fire;
    logic [7:0]         emit_byte;

    // Match-code split
    always_comb
    begin
        if (cfg.distance_bits < DBITS_MIN)
            bits_eff = DBITS_MIN;
        else if (cfg.distance_bits > DBITS_MAX)
            bits_eff = DBITS_MAX;
        else
            bits_eff = cfg.distance_bits;
        dist_mask = (CODE_W'(1) << bits_eff) - CODE_W'(1);
        dist_m1   = tok_reg.match_code & dist_mask;
        distance  = dist_m1 + CODE_W'(1);
        len_shift = tok_reg.match_code >> bits_eff;
        match_len = len_shift[LEN_W-1:0] + LEN_W'(MIN_MATCH);
        too_far   = 32'(distance) > WINDOW_DEPTH;
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign emit_byte = tok_reg.is_match ? ram_rdata : tok_reg.literal;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CHECK_DONE;
            end
            ST_CHECK_DONE:
            begin
                if (alu_rsp.borrow || (alu_rsp.sum == '0))
                    state_next = ST_ERROR;
                else if (!tok_reg.is_match)
                    state_next = ST_EMIT;
                else
                    state_next = ST_CHECK_LEN;
            end
            ST_CHECK_LEN:
            begin
                state_next = alu_rsp.borrow ? ST_ERROR : ST_CHECK_DIST;
            end
            ST_CHECK_DIST:
            begin
                state_next = (alu_rsp.borrow || too_far) ? ST_ERROR : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = (len_reg == LEN_W'(1)) ? ST_IDLE : ST_READ;
            end
            ST_ERROR:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of each step
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        emit_fire = 1'b0;
        err_fire  = 1'b0;
        alu_req   = '{op: ALU_ADD, a: '0, b: '0};
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CHECK_DONE:
            begin
                alu_req = '{op: ALU_SUB, a: cfg.total_size, b: produced_reg};
            end
            ST_CHECK_LEN:
            begin
                alu_req = '{op: ALU_SUB, a: remaining_reg, b: SIZE_W'(match_len)};
            end
            ST_CHECK_DIST:
            begin
                alu_req = '{op: ALU_SUB, a: produced_reg, b: SIZE_W'(distance)};
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_EMIT:
            begin
                alu_req   = '{op: ALU_ADD, a: produced_reg, b: SIZE_W'(1)};
                emit_fire = slot_free;
            end
            ST_ERROR:
            begin
                err_fire = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign ram_we    = emit_fire;
    assign ram_waddr = produced_reg[ADDR_W-1:0];
    assign ram_wdata = emit_byte;
    assign ram_raddr = src_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            produced_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
                produced_reg <= alu_rsp.sum;
            if (emit_fire || err_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    tok_reg <= in_data;
            end
            ST_CHECK_DONE:
            begin
                remaining_reg <= alu_rsp.sum;
                len_reg       <= tok_reg.is_match ? match_len : LEN_W'(1);
                err_reg       <= ERR_FAR;
            end
            ST_CHECK_LEN:
            begin
                err_reg <= ERR_OVERRUN;
            end
            ST_CHECK_DIST:
            begin
                src_reg <= alu_rsp.sum[ADDR_W-1:0];
                err_reg <= ERR_FAR;
            end
            ST_READ:
            begin
                src_reg <= src_reg + ADDR_W'(1);   // wraps round the window
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    len_reg <= len_reg - LEN_W'(1);
                    out_reg <= '{out_byte:    emit_byte,
                                 run_last:    (len_reg == LEN_W'(1)),
                                 stream_done: (alu_rsp.sum == cfg.total_size),
                                 error_code:  ERR_NONE};
                end
            end
            ST_ERROR:
            begin
                if (err_fire)
                    out_reg <= '{out_byte: 8'd0, run_last: 1'b1,
                                 stream_done: 1'b0, error_code: err_reg};
            end
            default:
            begin
                len_reg <= len_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

`default_nettype wire

[hdl/ulz_checker.sv]
// ----------------------------------------------------------------------------
// ulz_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ulz_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_ready,
    input wire ulz_pkg::out_t out_beat,
    input wire                out_valid,
    input wire                out_ready
);
    import ulz_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("result beat changed while stalled");

    // Busy after taking a token
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("token taken while busy");

    // Error beats are zero, marked last and never complete the stream
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_beat.error_code != ERR_NONE) |->
        (out_beat.out_byte == 8'd0) && out_beat.run_last && !out_beat.stream_done)
        else $error("malformed error beat");

    // The byte that completes the stream ends its token
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.stream_done |-> out_beat.run_last)
        else $error("stream done inside a run");

endmodule

bind ulz_lz77_decompressor_top ulz_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_beat  (out_beat),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

`default_nettype wire
